// ===== design/integer_alu_with_hi_lo_muldiv_assert.svh =====
// assertion macros used by the checker file iam_checker.sv
`ifndef INTEGER_ALU_WITH_HI_LO_MULDIV_ASSERT_SVH
`define INTEGER_ALU_WITH_HI_LO_MULDIV_ASSERT_SVH

// property that must hold at every edge outside reset
`define IAM_ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define IAM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/iam_pkg.sv =====
// ----------------------------------------------------------------------------
// iam_pkg
// types and command codes for the integer alu with hi/lo muldiv
// ----------------------------------------------------------------------------
package iam_pkg;

    typedef enum logic [4:0] {
        CMD_ADD, CMD_ADDU, CMD_SUB, CMD_SUBU, CMD_AND, CMD_OR, CMD_XOR, CMD_NOR,
        CMD_SLT, CMD_SLTU, CMD_ADDI, CMD_ADDIU, CMD_ANDI, CMD_ORI, CMD_XORI,
        CMD_SLTI, CMD_SLTIU, CMD_LUI, CMD_SLL, CMD_SRL, CMD_SRA, CMD_SLLV,
        CMD_SRLV, CMD_SRAV, CMD_MULT, CMD_MULTU, CMD_DIV, CMD_DIVU, CMD_MFHI,
        CMD_MFLO, CMD_MTHI, CMD_MTLO
    } cmd_t;

    typedef struct packed {
        logic [4:0]  command;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [15:0] immediate;
        logic [4:0]  shift_amount;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] result;
        logic        write_enable;
        logic        overflow;
    } out_beat_t;

    // request to the muldiv sequencer
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        is_signed;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;

endpackage

// ===== design/iam_muldiv.sv =====
// ----------------------------------------------------------------------------
// iam_muldiv
// shift-add multiplier and restoring divider, each with its own 33-bit adder or subtractor
// ----------------------------------------------------------------------------
module iam_muldiv
    import iam_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  md_req_t     req,
    output logic        done,
    output logic [31:0] hi,
    output logic [31:0] lo
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

    state_t      state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] acc_reg, acc_next;     // partial product high / remainder
    logic [31:0] q_reg, q_next;         // multiplier bits / quotient
    logic [31:0] m_reg, m_next;         // magnitude of b
    logic        div_reg, div_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic        zero_reg, zero_next;
    logic [31:0] a_reg, a_next;
    logic        done_reg, done_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;

    logic [31:0] ma, mb;
    logic [32:0] sum, trial, rem_sh;
    logic [63:0] prod_mag;

    always_comb begin
        ma = (req.is_signed && req.a[31]) ? (32'd0 - req.a) : req.a;
        mb = (req.is_signed && req.b[31]) ? (32'd0 - req.b) : req.b;
        sum    = {1'b0, acc_reg[31:0]} + (q_reg[0] ? {1'b0, m_reg} : 33'd0);
        rem_sh = {acc_reg[31:0], q_reg[31]};
        trial  = rem_sh - {1'b0, m_reg};
        prod_mag = {acc_reg[31:0], q_reg};
    end

    always_comb begin
        state_next = state_reg; cnt_next = cnt_reg; acc_next = acc_reg;
        q_next = q_reg; m_next = m_reg; div_next = div_reg;
        neg_q_next = neg_q_reg; neg_r_next = neg_r_reg; zero_next = zero_reg;
        a_next = a_reg; done_next = 1'b0; hi_next = hi_reg; lo_next = lo_reg;
        case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    state_next = S_RUN;
                    cnt_next   = 6'd0;
                    acc_next   = 33'd0;
                    q_next     = ma;
                    m_next     = mb;
                    div_next   = req.is_div;
                    neg_q_next = req.is_signed && (req.a[31] ^ req.b[31]);
                    neg_r_next = req.is_signed && req.a[31];
                    zero_next  = (req.b == 32'd0);
                    a_next     = req.a;
                end
            end
            S_RUN: begin
                if (div_reg) begin
                    if (!trial[32]) begin
                        acc_next = trial;
                        q_next   = {q_reg[30:0], 1'b1};
                    end else begin
                        acc_next = rem_sh;
                        q_next   = {q_reg[30:0], 1'b0};
                    end
                end else begin
                    // shift product right, new bit enters top of q
                    acc_next = {1'b0, sum[32:1]};
                    q_next   = {sum[0], q_reg[31:1]};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) state_next = S_FIX;
            end
            S_FIX: begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (div_reg) begin
                    if (zero_reg) begin
                        lo_next = (neg_r_reg) ? 32'd1 : 32'hFFFF_FFFF;
                        hi_next = a_reg;
                    end else begin
                        lo_next = neg_q_reg ? (32'd0 - q_reg) : q_reg;
                        hi_next = neg_r_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
                    end
                end else begin
                    {hi_next, lo_next} = neg_q_reg ? (64'd0 - prod_mag) : prod_mag;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg <= cnt_next; acc_reg <= acc_next; q_reg <= q_next; m_reg <= m_next;
        div_reg <= div_next; neg_q_reg <= neg_q_next; neg_r_reg <= neg_r_next;
        zero_reg <= zero_next; a_reg <= a_next; hi_reg <= hi_next; lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

// ===== design/integer_alu_with_hi_lo_muldiv.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_hi_lo_muldiv
// 32-bit integer alu with hi/lo registers and a sequential multiply/divide
// ----------------------------------------------------------------------------
// usage
//   s_ channel carries one command beat (command, operands, immediate,
//   shift amount); m_ channel returns one result beat per command
//   (result, write_enable, overflow)
//   alu, shift, compare and hi/lo move commands: result registered at the
//   accepting edge and taken at the earliest in the following cycle; the next beat
//   is accepted as soon as the output register is free or being drained
//   mult/multu/div/divu: a shift-add / restoring-divide unit runs 32
//   iterations, then a fixup state that raises a registered done; m_valid
//   rises from the output register once done is seen, and s_ready is low
//   until then, so no new beat is accepted while such a command is in flight
//   reset (aresetn low, synchronous) clears hi, lo, the sequencer and the
//   output valid
//   if the receiver stalls (m_ready low) the result beat holds and s_ready
//   stays low until it is taken
// ----------------------------------------------------------------------------
module integer_alu_with_hi_lo_muldiv
    import iam_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic        busy_reg, busy_next;     // muldiv in flight
    logic        ov_reg, ov_next;         // output holds a beat
    out_beat_t   od_reg, od_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;

    md_req_t     md_req;
    logic        md_done;
    logic [31:0] md_hi, md_lo;

    logic        acc;
    logic [31:0] a, b, simm, zimm, sum, diff, sumi, sres;
    logic [4:0]  sh;
    out_beat_t   alu;
    cmd_t        cmd;

    // accept only when not busy and output slot free or draining
    assign s_ready = !busy_reg && (!ov_reg || m_ready);
    assign acc     = s_valid && s_ready;

    always_comb begin
        cmd  = cmd_t'(s_data.command);
        a    = s_data.operand_a;
        b    = s_data.operand_b;
        simm = {{16{s_data.immediate[15]}}, s_data.immediate};
        zimm = {16'd0, s_data.immediate};
        sum  = a + b;
        diff = a - b;
        sumi = a + simm;
        sh   = (cmd == CMD_SLL || cmd == CMD_SRL || cmd == CMD_SRA)
               ? s_data.shift_amount : a[4:0];
        sres = 32'd0;
        alu  = '{result: 32'd0, write_enable: 1'b1, overflow: 1'b0};
        case (cmd)
            CMD_ADD: begin
                if (!(a[31] ^ b[31]) && (a[31] ^ sum[31])) begin
                    alu.write_enable = 1'b0; alu.overflow = 1'b1;
                end else alu.result = sum;
            end
            CMD_ADDU: alu.result = sum;
            CMD_SUB: begin
                if ((a[31] ^ b[31]) && (a[31] ^ diff[31])) begin
                    alu.write_enable = 1'b0; alu.overflow = 1'b1;
                end else alu.result = diff;
            end
            CMD_SUBU:  alu.result = diff;
            CMD_AND:   alu.result = a & b;
            CMD_OR:    alu.result = a | b;
            CMD_XOR:   alu.result = a ^ b;
            CMD_NOR:   alu.result = ~(a | b);
            CMD_SLT:   alu.result = {31'd0, $signed(a) < $signed(b)};
            CMD_SLTU:  alu.result = {31'd0, a < b};
            CMD_ADDI: begin
                if (!(a[31] ^ simm[31]) && (a[31] ^ sumi[31])) begin
                    alu.write_enable = 1'b0; alu.overflow = 1'b1;
                end else alu.result = sumi;
            end
            CMD_ADDIU: alu.result = sumi;
            CMD_ANDI:  alu.result = a & zimm;
            CMD_ORI:   alu.result = a | zimm;
            CMD_XORI:  alu.result = a ^ zimm;
            CMD_SLTI:  alu.result = {31'd0, $signed(a) < $signed(simm)};
            CMD_SLTIU: alu.result = {31'd0, a < simm};
            CMD_LUI:   alu.result = {s_data.immediate, 16'd0};
            CMD_SLL, CMD_SLLV: alu.result = b << sh;
            CMD_SRL, CMD_SRLV: alu.result = b >> sh;
            CMD_SRA, CMD_SRAV: begin
                sres = $unsigned($signed(b) >>> sh);
                alu.result = sres;
            end
            CMD_MFHI:  alu.result = hi_reg;
            CMD_MFLO:  alu.result = lo_reg;
            default:   alu.write_enable = 1'b0;  // muldiv and move-to
        endcase
    end

    always_comb begin
        md_req.start     = acc && (cmd == CMD_MULT || cmd == CMD_MULTU ||
                                   cmd == CMD_DIV  || cmd == CMD_DIVU);
        md_req.is_div    = (cmd == CMD_DIV || cmd == CMD_DIVU);
        md_req.is_signed = (cmd == CMD_MULT || cmd == CMD_DIV);
        md_req.a         = a;
        md_req.b         = b;
    end

    iam_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .done    (md_done),
        .hi      (md_hi),
        .lo      (md_lo)
    );

    always_comb begin
        busy_next = busy_reg;
        ov_next   = ov_reg && !m_ready;
        od_next   = od_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (md_done) begin
            busy_next = 1'b0;
            hi_next   = md_hi;
            lo_next   = md_lo;
            ov_next   = 1'b1;
            od_next   = '{result: 32'd0, write_enable: 1'b0, overflow: 1'b0};
        end
        if (acc) begin
            if (md_req.start) begin
                busy_next = 1'b1;
            end else begin
                ov_next = 1'b1;
                od_next = alu;
                if (cmd == CMD_MTHI) hi_next = a;
                if (cmd == CMD_MTLO) lo_next = a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            hi_reg   <= 32'd0;
            lo_reg   <= 32'd0;
        end else begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
        end
        od_reg <= od_next;
    end

    assign m_valid = ov_reg;
    assign m_data  = od_reg;

endmodule

// ===== design/iam_checker.sv =====
// ----------------------------------------------------------------------------
// iam_checker
// port-level checks for the integer alu with hi/lo muldiv
// ----------------------------------------------------------------------------
`include "integer_alu_with_hi_lo_muldiv_assert.svh"

module iam_checker
    import iam_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // a stalled result beat holds
    `IAM_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // overflow never comes with a register write
    `IAM_ASSERT_ALWAYS(a_ovf_we, aclk, aresetn, !(m_valid && m_data.overflow && m_data.write_enable))
    // an accepted alu beat shows up on the next cycle
    `IAM_ASSERT_NEXT(a_alu_lat, aclk, aresetn,
        s_valid && s_ready && s_data.command != CMD_MULT && s_data.command != CMD_MULTU &&
        s_data.command != CMD_DIV && s_data.command != CMD_DIVU, m_valid)
    // an accepted mult or divu beat closes the input; the design keeps it closed until the muldiv finishes
    `IAM_ASSERT_NEXT(a_md_busy, aclk, aresetn,
        s_valid && s_ready && (s_data.command == CMD_MULT || s_data.command == CMD_DIVU),
        !s_ready)

endmodule

bind integer_alu_with_hi_lo_muldiv iam_checker u_iam_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
